@@ src/kmbd_pkg.sv @@
// shared types and constants for the keyboard/mouse byte decoder
// no dependencies
package kmbd_pkg;

    localparam logic [7:0] HEADER_MIN = 8'hF8;
    localparam int         POS_W      = 10;
    localparam int         SUM_W      = POS_W + 2;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_MAX_X    = 2'd0;
    localparam logic [1:0] CFG_MAX_Y    = 2'd1;
    localparam logic [1:0] CFG_DELAY    = 2'd2;
    localparam logic [1:0] CFG_INTERVAL = 2'd3;

    localparam logic [POS_W-1:0] MAX_X_RST    = 10'd639;
    localparam logic [POS_W-1:0] MAX_Y_RST    = 10'd399;
    localparam logic [7:0]       DELAY_RST    = 8'd18;
    localparam logic [7:0]       INTERVAL_RST = 8'd22;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DX   = 3'b010,
        PH_DY   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] now_time;
        logic        queue_full;
    } in_word_t;

    typedef struct packed {
        logic             key_valid;
        logic [6:0]       key_code;
        logic             key_held;
        logic [15:0]      first_repeat_at;
        logic [15:0]      next_repeat_at;
        logic             pointer_moved;
        logic [POS_W-1:0] pointer_x;
        logic [POS_W-1:0] pointer_y;
        logic [7:0]       button_byte;
    } out_word_t;

    typedef struct packed {
        logic [POS_W-1:0] max_x;
        logic [POS_W-1:0] max_y;
        logic [7:0]       repeat_delay;
        logic [7:0]       repeat_interval;
    } cfg_t;

endpackage

@@ src/kmbd_cfg.sv @@
// configuration registers: pointer limits and key repeat timing
// depends on kmbd_pkg
module kmbd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [kmbd_pkg::POS_W-1:0]  cfg_data,
    output kmbd_pkg::cfg_t              cfg
);

    kmbd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_x           <= kmbd_pkg::MAX_X_RST;
            cfg_reg.max_y           <= kmbd_pkg::MAX_Y_RST;
            cfg_reg.repeat_delay    <= kmbd_pkg::DELAY_RST;
            cfg_reg.repeat_interval <= kmbd_pkg::INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kmbd_pkg::CFG_MAX_X:    cfg_reg.max_x           <= cfg_data;
                kmbd_pkg::CFG_MAX_Y:    cfg_reg.max_y           <= cfg_data;
                kmbd_pkg::CFG_DELAY:    cfg_reg.repeat_delay    <= cfg_data[7:0];
                kmbd_pkg::CFG_INTERVAL: cfg_reg.repeat_interval <= cfg_data[7:0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/kmbd_core.sv @@
// decoder state and per-byte update: packet phase, pointer, held key, deadlines
// depends on kmbd_pkg
module kmbd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  kmbd_pkg::in_word_t   word,
    input  kmbd_pkg::cfg_t       cfg,
    output kmbd_pkg::out_word_t  result
);

    kmbd_pkg::phase_t              phase_reg, phase_next;
    logic [kmbd_pkg::POS_W-1:0]    pos_x_reg, pos_x_next;
    logic [kmbd_pkg::POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [6:0]                    held_code_reg, held_code_next;
    logic                          hold_reg, hold_next;
    logic [15:0]                   delay_dl_reg, delay_dl_next;
    logic [15:0]                   interval_dl_reg, interval_dl_next;
    logic [7:0]                    buttons_reg, buttons_next;

    logic                          is_dx;
    logic [kmbd_pkg::POS_W-1:0]    axis_pos;
    logic [kmbd_pkg::POS_W-1:0]    axis_lim;
    logic signed [kmbd_pkg::SUM_W-1:0] axis_sum;
    logic [kmbd_pkg::POS_W-1:0]    axis_new;
    logic                          key_ok;

    // one shared clamp adder, x or y depending on phase
    always_comb
    begin
        is_dx    = (phase_reg == kmbd_pkg::PH_DX);
        axis_pos = is_dx ? pos_x_reg : pos_y_reg;
        axis_lim = is_dx ? cfg.max_x : cfg.max_y;
        axis_sum = signed'({2'b00, axis_pos})
                 + signed'({{(kmbd_pkg::SUM_W-8){word.rx_byte[7]}}, word.rx_byte});
        if (axis_sum > signed'({2'b00, axis_lim}))
            axis_new = axis_lim;
        else if (axis_sum[kmbd_pkg::SUM_W-1])
            axis_new = '0;
        else
            axis_new = axis_sum[kmbd_pkg::POS_W-1:0];
    end

    always_comb
    begin
        phase_next       = kmbd_pkg::PH_IDLE;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        held_code_next   = held_code_reg;
        hold_next        = hold_reg;
        delay_dl_next    = delay_dl_reg;
        interval_dl_next = interval_dl_reg;
        buttons_next     = buttons_reg;
        key_ok           = 1'b0;

        unique case (phase_reg)
            kmbd_pkg::PH_DX:
            begin
                pos_x_next = axis_new;
                phase_next = kmbd_pkg::PH_DY;
            end
            kmbd_pkg::PH_DY:
            begin
                pos_y_next = axis_new;
                phase_next = kmbd_pkg::PH_IDLE;
            end
            default:
            begin
                if (word.rx_byte >= kmbd_pkg::HEADER_MIN)
                begin
                    buttons_next = word.rx_byte;
                    phase_next   = kmbd_pkg::PH_DX;
                end
                else if (!word.rx_byte[7])
                begin
                    if (!word.queue_full)
                    begin
                        key_ok           = 1'b1;
                        held_code_next   = word.rx_byte[6:0];
                        hold_next        = 1'b1;
                        delay_dl_next    = word.now_time + {8'd0, cfg.repeat_delay};
                        interval_dl_next = word.now_time + {8'd0, cfg.repeat_interval};
                    end
                end
                else if (word.rx_byte[6:0] == held_code_reg)
                begin
                    // break code of the held key
                    hold_next = 1'b0;
                end
            end
        endcase

        result.key_valid       = key_ok;
        result.key_code        = key_ok ? word.rx_byte[6:0] : 7'd0;
        result.key_held        = hold_next;
        result.first_repeat_at = delay_dl_next;
        result.next_repeat_at  = interval_dl_next;
        result.pointer_moved   = (phase_reg != kmbd_pkg::PH_IDLE);
        result.pointer_x       = pos_x_next;
        result.pointer_y       = pos_y_next;
        result.button_byte     = buttons_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= kmbd_pkg::PH_IDLE;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            held_code_reg   <= '0;
            hold_reg        <= 1'b0;
            delay_dl_reg    <= '0;
            interval_dl_reg <= '0;
            buttons_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            held_code_reg   <= held_code_next;
            hold_reg        <= hold_next;
            delay_dl_reg    <= delay_dl_next;
            interval_dl_reg <= interval_dl_next;
            buttons_reg     <= buttons_next;
        end
    end

endmodule

@@ src/keyboard_mouse_byte_decoder_top.sv @@
// top level of the keyboard/mouse byte decoder: input register, core, result register
// depends on kmbd_pkg, kmbd_cfg, kmbd_core
//
// Takes one received byte per word and returns one result word for it. A
// mouse header (0xF8..0xFF) is followed by a signed dx and dy byte that move
// a pointer clamped to 0..max_x / 0..max_y; bytes below 0x80 are make codes
// that set the hold flag and two repeat deadlines unless queue_full is set;
// the break code of the held key clears the hold. One word is taken every
// cycle while the result is not stalled; the decode and clamp adder lie
// between the input register and the result register, which offers the result.
// A stalled result holds the input register, so at most two words are in
// flight. Configuration writes take effect at once and belong to idle periods.
module keyboard_mouse_byte_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kmbd_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output kmbd_pkg::out_word_t         out_data,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [kmbd_pkg::POS_W-1:0]  cfg_data
);

    kmbd_pkg::cfg_t      cfg;
    kmbd_pkg::in_word_t  in_word_reg;
    logic                in_full_reg;
    kmbd_pkg::out_word_t result;
    kmbd_pkg::out_word_t out_word_reg;
    logic                out_full_reg;
    logic                step;

    assign step     = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || step;

    kmbd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kmbd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_word_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_full_reg <= in_valid;
            if (step)
                out_full_reg <= 1'b1;
            else if (out_ready)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_word_reg <= in_data;
        if (step)
            out_word_reg <= result;
    end

    assign out_valid = out_full_reg;
    assign out_data  = out_word_reg;

    // an accepted key always leaves the key held
    a_key_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.key_valid |-> out_data.key_held)
        else $error("accepted key without hold");

    // a byte is either a key or a movement, never both
    a_key_or_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.key_valid && out_data.pointer_moved))
        else $error("key and movement in one word");

    // a stalled result is not overwritten by the core
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_full_reg && !out_ready |-> !step)
        else $error("result register overwritten");

    // an empty input register always takes a word
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_full_reg |-> in_ready)
        else $error("input register empty but not ready");

endmodule
